// ===== sv/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants of the RGB to HSV converter
// Holds the pixel and result payload types, the divider stage record and
// the widths that follow from the channel and fraction sizes.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;

  // One integer bit plus the fraction bits come out of the divider chain.
  localparam int QUOT_BITS     = FRACTION_BITS + 1;
  // Hue divisor is six times the chroma.
  localparam int HUE_DIV_BITS  = CHANNEL_BITS + 3;
  // A partial remainder stays below twice its divisor.
  localparam int HUE_REM_BITS  = HUE_DIV_BITS + 1;
  localparam int SAT_REM_BITS  = CHANNEL_BITS + 1;
  // Signed width of the hue numerator before the absolute value.
  localparam int SUM_BITS      = CHANNEL_BITS + 5;
  // Number of divider cells, one per quotient bit.
  localparam int NUM_CELLS     = QUOT_BITS;

  localparam logic [FRACTION_BITS-1:0] FRAC_MAX = {FRACTION_BITS{1'b1}};

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  brightness;
  } hsv_t;

  // State of both divisions as it travels down the chain of cells.
  typedef struct packed {
    logic [HUE_REM_BITS-1:0] hue_rem;
    logic [HUE_DIV_BITS-1:0] hue_div;
    logic [QUOT_BITS-1:0]    hue_quot;
    logic [SAT_REM_BITS-1:0] sat_rem;
    logic [CHANNEL_BITS-1:0] sat_div;
    logic [QUOT_BITS-1:0]    sat_quot;
    logic [CHANNEL_BITS-1:0] brightness;
  } div_stage_t;

endpackage

// ===== sv/rth_front.sv =====
// ----------------------------------------------------------------------------
// rth_front: channel ordering and divider setup
// Brings the largest channel to the top by conditional swaps, tracks the
// hue offset and registers dividends and divisors for the divider chain.
// ----------------------------------------------------------------------------
module rth_front import rth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_t     in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_stage_t out_data
);

  logic [CHANNEL_BITS-1:0]  top;
  logic [CHANNEL_BITS-1:0]  mid;
  logic [CHANNEL_BITS-1:0]  low;
  logic [CHANNEL_BITS-1:0]  swap;
  logic signed [3:0]        k6;
  logic [CHANNEL_BITS-1:0]  min_val;
  logic [CHANNEL_BITS-1:0]  chroma;
  logic signed [SUM_BITS-1:0] offset_term;
  logic signed [SUM_BITS-1:0] diff_term;
  logic signed [SUM_BITS-1:0] num_s;
  logic [SUM_BITS-1:0]      num_abs;
  logic [HUE_DIV_BITS-1:0]  hue_num;
  logic [HUE_DIV_BITS-1:0]  hue_div;
  logic [CHANNEL_BITS-1:0]  sat_div;
  div_stage_t               stage_nxt;
  div_stage_t               stage_r;
  logic                     valid_r;

  // Two swaps bring the largest channel to top; follow the offset in sixths.
  always_comb begin
    top  = in_data.red;
    mid  = in_data.green;
    low  = in_data.blue;
    swap = '0;
    k6   = 4'sd0;
    if (mid < low) begin
      swap = mid;
      mid  = low;
      low  = swap;
      k6   = -4'sd6;
    end
    if (top < mid) begin
      swap = top;
      top  = mid;
      mid  = swap;
      k6   = -4'sd2 - k6;
    end
  end

  // Chroma and the hue numerator as an absolute value.
  always_comb begin
    min_val     = (mid < low) ? mid : low;
    chroma      = top - min_val;
    offset_term = SUM_BITS'(k6) * $signed(SUM_BITS'(chroma));
    diff_term   = $signed(SUM_BITS'(mid)) - $signed(SUM_BITS'(low));
    num_s       = offset_term + diff_term;
    num_abs     = (num_s < 0) ? SUM_BITS'(-num_s) : SUM_BITS'(num_s);
  end

  // A zero divisor is replaced by one with a zero dividend, giving zero.
  always_comb begin
    if (chroma == '0) begin
      hue_num = '0;
      hue_div = HUE_DIV_BITS'(1);
    end else begin
      hue_num = num_abs[HUE_DIV_BITS-1:0];
      hue_div = (HUE_DIV_BITS'(chroma) << 2) + (HUE_DIV_BITS'(chroma) << 1);
    end
    sat_div = (top == '0) ? CHANNEL_BITS'(1) : top;
  end

  always_comb begin
    stage_nxt.hue_rem    = HUE_REM_BITS'(hue_num);
    stage_nxt.hue_div    = hue_div;
    stage_nxt.hue_quot   = '0;
    stage_nxt.sat_rem    = SAT_REM_BITS'(chroma);
    stage_nxt.sat_div    = sat_div;
    stage_nxt.sat_quot   = '0;
    stage_nxt.brightness = top;
  end

  // Stage register; it takes a transfer when empty or draining.
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = stage_r;

endmodule

// ===== sv/rth_div_cell.sv =====
// ----------------------------------------------------------------------------
// rth_div_cell: one restoring division step for hue and saturation
// Develops one quotient bit of each division and hands the doubled partial
// remainder to the next cell.
// ----------------------------------------------------------------------------
module rth_div_cell import rth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_stage_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_stage_t out_data
);

  logic [HUE_REM_BITS-1:0] hue_div_ext;
  logic [HUE_REM_BITS-1:0] hue_diff;
  logic                    hue_bit;
  logic [SAT_REM_BITS-1:0] sat_div_ext;
  logic [SAT_REM_BITS-1:0] sat_diff;
  logic                    sat_bit;
  div_stage_t              stage_nxt;
  div_stage_t              stage_r;
  logic                    valid_r;

  // Compare, subtract when it fits, then double the remainder.
  always_comb begin
    hue_div_ext = HUE_REM_BITS'(in_data.hue_div);
    hue_bit     = in_data.hue_rem >= hue_div_ext;
    hue_diff    = hue_bit ? (in_data.hue_rem - hue_div_ext) : in_data.hue_rem;
    sat_div_ext = SAT_REM_BITS'(in_data.sat_div);
    sat_bit     = in_data.sat_rem >= sat_div_ext;
    sat_diff    = sat_bit ? (in_data.sat_rem - sat_div_ext) : in_data.sat_rem;

    stage_nxt            = in_data;
    stage_nxt.hue_rem    = hue_diff << 1;
    stage_nxt.hue_quot   = {in_data.hue_quot[QUOT_BITS-2:0], hue_bit};
    stage_nxt.sat_rem    = sat_diff << 1;
    stage_nxt.sat_quot   = {in_data.sat_quot[QUOT_BITS-2:0], sat_bit};
  end

  // Stage register; it takes a transfer when empty or draining.
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = stage_r;

endmodule

// ===== sv/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: pipelined RGB to HSV pixel conversion
//
//   Channel | Direction | Payload | Handshake
//   in_     | input     | pixel_t | in_valid / in_ready
//   out_    | output    | hsv_t   | out_valid / out_ready
//
// One pixel is taken per clock while the output does not stall; each result
// passes one setup stage, then 17 divider cells, one quotient bit each.
// Reset clears only the stage valid bits; the pipeline is empty afterwards.
// Each stage holds while the stage after it is full and stalled, so a
// stalled output still lets pixels fill any empty stage upstream.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import rth_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hsv_t   out_data
);

  logic       chain_valid [NUM_CELLS+1];
  logic       chain_ready [NUM_CELLS+1];
  div_stage_t chain_data  [NUM_CELLS+1];
  div_stage_t last_stage;

  // Channel ordering and divider setup.
  rth_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // Row of divider cells.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  assign chain_ready[NUM_CELLS] = out_ready;
  assign last_stage             = chain_data[NUM_CELLS];
  assign out_valid              = chain_valid[NUM_CELLS];

  // A set integer bit means the fraction reached one and saturates.
  always_comb begin
    out_data.hue        = last_stage.hue_quot[QUOT_BITS-1] ? FRAC_MAX
                          : last_stage.hue_quot[FRACTION_BITS-1:0];
    out_data.saturation = last_stage.sat_quot[QUOT_BITS-1] ? FRAC_MAX
                          : last_stage.sat_quot[FRACTION_BITS-1:0];
    out_data.brightness = last_stage.brightness;
  end

  // An empty output stage lets the whole row advance, so input is open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  // Black pixels carry neither saturation nor hue.
  a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.brightness == '0) |->
      (out_data.saturation == '0) && (out_data.hue == '0))
    else $error("black pixel with nonzero saturation or hue");

  // Zero saturation means zero chroma, which forces zero hue.
  a_gray_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.saturation == '0) |-> (out_data.hue == '0))
    else $error("gray pixel with nonzero hue");

endmodule

// ===== tb/sv/rgb_to_hsv_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_test: self-checking bench for the RGB to HSV converter
// Pixels are pushed through the input channel in bursts with random gaps.
// Each accepted pixel is converted here with exact integer arithmetic into
// the hue, saturation and brightness it should produce. Every output transfer
// is checked field by field against the oldest pending conversion, while the
// output side stalls in patterns that change over the run.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;
  import rth_pkg::*;

  localparam int RANDOM_PIXELS = 850;
  localparam int SETTLE_CYCLES = 30;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  pixel_t in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  hsv_t   out_data;

  rgb_to_hsv_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_t pixel_backlog[$];
  hsv_t   expected_hsv[$];
  int     drain_points[$];
  int     pixels_sent = 0;
  int     total_pixels = 0;
  int     directed_pixels = 0;
  int     results_checked = 0;
  int     mismatch_count = 0;

  // Exact integer conversion: swaps bring the largest channel to the top while
  // the hue offset in sixths of a turn is tracked, then both fractions divide.
  function automatic hsv_t convert_pixel(pixel_t px);
    longint top, mid, low, k6, t, chroma, num;
    longint unsigned hue_q, sat_q;
    hsv_t res;
    top = longint'(px.red);
    mid = longint'(px.green);
    low = longint'(px.blue);
    k6 = 0;
    hue_q = 0;
    sat_q = 0;
    if (mid < low) begin
      t = mid; mid = low; low = t;
      k6 = -6;
    end
    if (top < mid) begin
      t = top; top = mid; mid = t;
      k6 = -2 - k6;
    end
    chroma = top - ((mid < low) ? mid : low);
    // A gray pixel has no hue.
    if (chroma != 0) begin
      num = k6 * chroma + (mid - low);
      if (num < 0) num = -num;
      hue_q = (longint'(num) << FRACTION_BITS) / longint'(6 * chroma);
      if (hue_q > 64'(FRAC_MAX)) hue_q = 64'(FRAC_MAX);
    end
    // A black pixel has no saturation.
    if (top != 0) begin
      sat_q = (longint'(chroma) << FRACTION_BITS) / longint'(top);
      if (sat_q > 64'(FRAC_MAX)) sat_q = 64'(FRAC_MAX);
    end
    res.hue = hue_q[FRACTION_BITS-1:0];
    res.saturation = sat_q[FRACTION_BITS-1:0];
    res.brightness = top[CHANNEL_BITS-1:0];
    return res;
  endfunction

  task automatic queue_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red = r[CHANNEL_BITS-1:0];
    px.green = g[CHANNEL_BITS-1:0];
    px.blue = b[CHANNEL_BITS-1:0];
    pixel_backlog.push_back(px);
    total_pixels++;
  endtask

  // Picks one channel value that favors the ends of the range.
  function automatic int edge_value();
    int pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0: return 0;
      1: return 1;
      2: return 254;
      3: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps. A new pixel
  // is only presented once the previous transfer has completed.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_hsv.push_back(convert_pixel(in_data));
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (drain_points.size() != 0 && pixels_sent == drain_points[0]) begin
          // Hold off until every pending result has come back.
          if (expected_hsv.size() == 0) void'(drain_points.pop_front());
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          in_data <= pixel_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Some bursts are long and gapless, others short and choppy.
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(30, 120);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(0, 12);
              gap_left = $urandom_range(1, 12);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern switches between modes every so often.
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  int  stall_phase = 0;
  logic ready_level = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      // Check the transfer that completes at this edge.
      if (out_valid && out_ready) begin
        if (expected_hsv.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result: hue=%h sat=%h val=%h", $realtime,
                     out_data.hue, out_data.saturation, out_data.brightness);
        end else begin
          hsv_t want;
          want = expected_hsv.pop_front();
          results_checked++;
          if (out_data.hue !== want.hue || out_data.saturation !== want.saturation ||
              out_data.brightness !== want.brightness) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] mismatch: expected hue=%h sat=%h val=%h, got hue=%h sat=%h val=%h",
                       $realtime, want.hue, want.saturation, want.brightness,
                       out_data.hue, out_data.saturation, out_data.brightness);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (stall_phase % 5) != 0;
        default: begin
          // Long stretches of ready and long stalls in turn.
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 30);
            ready_level = !ready_level;
          end else begin
            hold_left--;
          end
          out_ready <= ready_level;
        end
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int sel, base;
    // Black, white, gray and the primaries and secondaries.
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(1, 1, 1);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    // Hue just below a full turn and the smallest nonzero chroma.
    queue_pixel(255, 0, 1);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(0, 1, 0);
    queue_pixel(255, 254, 255);
    queue_pixel(254, 255, 255);
    // Every ordering of three distinct channels, then two with a repeated channel.
    queue_pixel(200, 100, 50);
    queue_pixel(200, 50, 100);
    queue_pixel(100, 200, 50);
    queue_pixel(50, 200, 100);
    queue_pixel(100, 50, 200);
    queue_pixel(50, 100, 200);
    queue_pixel(170, 85, 85);
    queue_pixel(85, 170, 170);
    directed_pixels = total_pixels;
    drain_points.push_back(directed_pixels);
    drain_points.push_back(directed_pixels + RANDOM_PIXELS / 2);

    repeat (RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        5: begin
          base = $urandom_range(0, 255);
          queue_pixel(base, base, base);
        end
        6: begin
          base = $urandom_range(0, 255);
          case ($urandom_range(0, 2))
            0: queue_pixel(base, base, $urandom_range(0, 255));
            1: queue_pixel(base, $urandom_range(0, 255), base);
            default: queue_pixel($urandom_range(0, 255), base, base);
          endcase
        end
        7: queue_pixel(edge_value(), edge_value(), edge_value());
        8: queue_pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        9: begin
          base = $urandom_range(2, 253);
          queue_pixel(base + $urandom_range(0, 4) - 2, base + $urandom_range(0, 4) - 2,
                      base + $urandom_range(0, 4) - 2);
        end
        default: queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
      endcase
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pixels_sent < total_pixels) @(posedge clk);
    while (expected_hsv.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d directed and %0d random pixels with bursty input and stalled output.",
             directed_pixels, total_pixels - directed_pixels);
    $display("%0d results checked, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_hsv.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Timeout: %0d of %0d pixels sent, %0d results pending.",
             pixels_sent, total_pixels, expected_hsv.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== rgb_to_hsv_converter.f =====
sv/rth_pkg.sv
sv/rth_front.sv
sv/rth_div_cell.sv
sv/rgb_to_hsv_converter.sv
tb/sv/rgb_to_hsv_converter_test.sv
